@@ sv/double_ended_queue_unit_defines.svh @@
// Assertion macros used by the double-ended queue datapath.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Property must hold at every clock edge out of reset.
`define DEQU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("double_ended_queue_unit: assertion failed");

// Condition must never be seen at a clock edge out of reset.
`define DEQU_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("double_ended_queue_unit: forbidden condition seen");

`endif

@@ sv/dequ_pkg.sv @@
// Shared types and codes for the double-ended queue unit.
// No dependencies; used by the controller, datapath and top level.
package dequ_pkg;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned DataW   = 32;
  localparam int unsigned FillW   = 5;

  localparam logic [ModeW-1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [ModeW-1:0] MODE_PUSH_REAR  = 2'd1;
  localparam logic [ModeW-1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [ModeW-1:0] MODE_POP_REAR   = 2'd3;

  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic               load;
    logic               push_front;
    logic               push_rear;
    logic               pop_front;
    logic               pop_rear;
    logic [StatusW-1:0] status;
  } dequ_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dequ_sts_t;

endpackage

@@ sv/double_ended_queue_unit.sv @@
// Bounded double-ended queue of signed 32-bit values.
// Input channel: in_valid_i / in_stall_o carry mode_i and push_value_i.
// Output channel: out_valid_o / out_stall_i carry pop_value_o, status_o
// and fill_count_o; every accepted item yields exactly one result item.
// The result is registered and presented the cycle after the item is accepted.
// Throughput: one item per cycle while the output is not stalled; the
// single ring-buffer access per item, with its registered read, sets this.
// The next item is taken in the same cycle that the pending result leaves.
// A stalled result holds on the output and blocks further input until taken.
// Pushes into a full queue report status full; pops from an empty queue
// report status empty with a zero value; the queue is left unchanged.
// Reset empties the queue at once; slot contents are not cleared.
// Depends on dequ_pkg, dequ_ctrl and dequ_dp.
module double_ended_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dequ_pkg::ModeW-1:0]          mode_i,
  input  logic signed [dequ_pkg::DataW-1:0]   push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dequ_pkg::DataW-1:0]   pop_value_o,
  output logic [dequ_pkg::StatusW-1:0]        status_o,
  output logic [dequ_pkg::FillW-1:0]          fill_count_o
);

  dequ_pkg::dequ_cmd_t        cmd;
  dequ_pkg::dequ_sts_t        sts;
  logic [dequ_pkg::DataW-1:0] pop_value;

  dequ_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dequ_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .push_value_i (push_value_i),
    .pop_value_o  (pop_value),
    .status_o     (status_o),
    .fill_count_o (fill_count_o)
  );

  assign pop_value_o = signed'(pop_value);

endmodule

@@ sv/dequ_ctrl.sv @@
// Controller of the double-ended queue unit: handshakes and operation decode.
// Depends on dequ_pkg; drives commands into dequ_dp.
module dequ_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dequ_pkg::ModeW-1:0]    mode_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  dequ_pkg::dequ_sts_t           sts_i,
  output dequ_pkg::dequ_cmd_t           cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StResp = 1'b1;

  logic state_q, state_d;
  logic in_ready;
  logic accept;

  assign out_valid_o = (state_q == StResp);
  assign in_ready    = (state_q == StIdle) || !out_stall_i;
  assign in_stall_o  = !in_ready;
  assign accept      = in_valid_i && in_ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StResp;
      end
      StResp: begin
        if (accept) state_d = StResp;
        else if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = accept;
    cmd_o.status     = dequ_pkg::STATUS_OK;
    unique case (mode_i)
      dequ_pkg::MODE_PUSH_FRONT: begin
        if (sts_i.full) cmd_o.status = dequ_pkg::STATUS_FULL;
        else cmd_o.push_front = accept;
      end
      dequ_pkg::MODE_PUSH_REAR: begin
        if (sts_i.full) cmd_o.status = dequ_pkg::STATUS_FULL;
        else cmd_o.push_rear = accept;
      end
      dequ_pkg::MODE_POP_FRONT: begin
        if (sts_i.empty) cmd_o.status = dequ_pkg::STATUS_EMPTY;
        else cmd_o.pop_front = accept;
      end
      dequ_pkg::MODE_POP_REAR: begin
        if (sts_i.empty) cmd_o.status = dequ_pkg::STATUS_EMPTY;
        else cmd_o.pop_rear = accept;
      end
      default: cmd_o.status = dequ_pkg::STATUS_OK;
    endcase
  end

endmodule

@@ sv/dequ_dp.sv @@
// Datapath of the double-ended queue unit: ring buffer, indices and result.
// Depends on dequ_pkg and double_ended_queue_unit_defines.svh.
`include "double_ended_queue_unit_defines.svh"

module dequ_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dequ_pkg::dequ_cmd_t             cmd_i,
  output dequ_pkg::dequ_sts_t             sts_o,
  input  logic [dequ_pkg::DataW-1:0]      push_value_i,
  output logic [dequ_pkg::DataW-1:0]      pop_value_o,
  output logic [dequ_pkg::StatusW-1:0]    status_o,
  output logic [dequ_pkg::FillW-1:0]      fill_count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [dequ_pkg::DataW-1:0] slots_q [DEPTH];
  logic [dequ_pkg::DataW-1:0] rd_q;

  logic [AW-1:0]               front_q, front_d;
  logic [CW-1:0]               count_q, count_d;
  logic                        pop_ok_q;
  logic [dequ_pkg::StatusW-1:0] status_q;

  logic [AW-1:0] front_dec, front_inc;
  logic [AW:0]   rear_wr_sum, rear_rd_sum;
  logic [AW-1:0] rear_wr, rear_rd;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en, rd_en;
  logic [31:0]   count_ext;

  assign sts_o.empty = (count_q == '0);
  assign sts_o.full  = (count_q == CW'(DEPTH));

  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

  assign rear_wr_sum = {1'b0, front_q} + {1'b0, AW'(count_q)};
  assign rear_rd_sum = {1'b0, front_q} + {1'b0, AW'(count_q - CW'(1))};
  assign rear_wr = (rear_wr_sum >= (AW+1)'(DEPTH)) ?
                   AW'(rear_wr_sum - (AW+1)'(DEPTH)) : AW'(rear_wr_sum);
  assign rear_rd = (rear_rd_sum >= (AW+1)'(DEPTH)) ?
                   AW'(rear_rd_sum - (AW+1)'(DEPTH)) : AW'(rear_rd_sum);

  assign wr_en   = cmd_i.push_front || cmd_i.push_rear;
  assign rd_en   = cmd_i.pop_front || cmd_i.pop_rear;
  assign wr_addr = cmd_i.push_front ? front_dec : rear_wr;
  assign rd_addr = cmd_i.pop_front ? front_q : rear_rd;

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    if (cmd_i.push_front) front_d = front_dec;
    if (cmd_i.pop_front)  front_d = front_inc;
    if (wr_en) count_d = count_q + CW'(1);
    if (rd_en) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) slots_q[wr_addr] <= push_value_i;
    if (rd_en) rd_q <= slots_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      pop_ok_q <= 1'b0;
      status_q <= dequ_pkg::STATUS_OK;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      if (cmd_i.load) begin
        pop_ok_q <= rd_en;
        status_q <= cmd_i.status;
      end
    end
  end

  assign count_ext    = 32'(count_q);
  assign pop_value_o  = pop_ok_q ? rd_q : '0;
  assign status_o     = status_q;
  assign fill_count_o = count_ext[dequ_pkg::FillW-1:0];

  `DEQU_ASSERT_NEVER(a_count_bound, count_q > CW'(DEPTH))
  `DEQU_ASSERT_NEVER(a_one_access, wr_en && rd_en)
  `DEQU_ASSERT(a_push_counts, wr_en |=> (count_q == $past(count_q) + CW'(1)))
  `DEQU_ASSERT(a_pop_counts, rd_en |=> (count_q == $past(count_q) - CW'(1)))

endmodule

@@ sim/tb_double_ended_queue_unit.sv @@
// Self-checking testbench for double_ended_queue_unit: a ring-buffer deque mirror
// predicts every result item and checks each one as it leaves the block.
// Depends on dequ_pkg and the double_ended_queue_unit RTL.
module tb_double_ended_queue_unit;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned ITEMS      = 850;
  localparam int unsigned QUIET_MAX  = 2000;
  localparam int unsigned HOLD_LEN   = 90;

  typedef struct packed {
    logic signed [dequ_pkg::DataW-1:0] pop_value;
    logic [dequ_pkg::StatusW-1:0]      status;
    logic [dequ_pkg::FillW-1:0]        fill_count;
  } deque_result_t;

  class deque_mirror;
    logic signed [dequ_pkg::DataW-1:0] ring [DEPTH];
    int unsigned                       head;
    int unsigned                       count;
    deque_result_t                     pending [$];
    int unsigned                       mismatches;

    function void note_item(logic [dequ_pkg::ModeW-1:0] mode,
                            logic signed [dequ_pkg::DataW-1:0] value);
      deque_result_t r;
      int unsigned   pos;
      r.pop_value = '0;
      r.status    = dequ_pkg::STATUS_OK;
      case (mode) inside
        dequ_pkg::MODE_PUSH_FRONT, dequ_pkg::MODE_PUSH_REAR: begin
          if (count >= DEPTH) begin
            r.status = dequ_pkg::STATUS_FULL;
          end else if (mode == dequ_pkg::MODE_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = value;
            count++;
          end else begin
            pos = (head + count) % DEPTH;
            ring[pos] = value;
            count++;
          end
        end
        default: begin
          if (count == 0) begin
            r.status = dequ_pkg::STATUS_EMPTY;
          end else if (mode == dequ_pkg::MODE_POP_FRONT) begin
            r.pop_value = ring[head];
            head = (head + 1) % DEPTH;
            count--;
          end else begin
            pos = (head + count - 1) % DEPTH;
            r.pop_value = ring[pos];
            count--;
          end
        end
      endcase
      r.fill_count = count[dequ_pkg::FillW-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [dequ_pkg::DataW-1:0] pop_value,
                               logic [dequ_pkg::StatusW-1:0] status,
                               logic [dequ_pkg::FillW-1:0] fill_count);
      deque_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: expected none, got pop_value %0d status %0d fill %0d",
                 $time, pop_value, status, fill_count);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (pop_value !== want.pop_value) begin
        $display("%0t: pop_value expected %0d got %0d", $time, want.pop_value, pop_value);
        mismatches++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, status);
        mismatches++;
      end
      if (fill_count !== want.fill_count) begin
        $display("%0t: fill_count expected %0d got %0d", $time, want.fill_count, fill_count);
        mismatches++;
      end
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [dequ_pkg::ModeW-1:0]        mode_i;
  logic signed [dequ_pkg::DataW-1:0] push_value_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [dequ_pkg::DataW-1:0] pop_value_o;
  logic [dequ_pkg::StatusW-1:0]      status_o;
  logic [dequ_pkg::FillW-1:0]        fill_count_o;

  deque_mirror mirror = new();
  bit          sender_eager;
  bit          receiver_eager;
  int unsigned results_taken;
  int unsigned quiet_cycles = 0;

  double_ended_queue_unit #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o),
    .fill_count_o (fill_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_wait(bit eager);
    if (eager) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic signed [dequ_pkg::DataW-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [dequ_pkg::ModeW-1:0] mode,
                           logic signed [dequ_pkg::DataW-1:0] value);
    int unsigned gap;
    gap = pick_wait(sender_eager);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    push_value_i <= value;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) mirror.note_item(mode_i, push_value_i);
      if (out_valid_o && !out_stall_i) begin
        mirror.check_result(pop_value_o, status_o, fill_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_MAX) begin
        $display("double_ended_queue_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned stall;
    out_stall_i    = 1'b0;
    receiver_eager = 1'b0;
    results_taken  = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (results_taken % 40 == 0) receiver_eager = ($urandom_range(0, 2) == 0);
      if (results_taken == 120 || results_taken == 520) begin
        stall = HOLD_LEN;
      end else begin
        stall = pick_wait(receiver_eager);
      end
      if (stall > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      results_taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned                sent;
    int unsigned                push_bias;
    logic [dequ_pkg::ModeW-1:0] mode;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = dequ_pkg::MODE_PUSH_FRONT;
    push_value_i = '0;
    sender_eager = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // single-entry pops from each end, then pops on an empty queue
    send_item(dequ_pkg::MODE_PUSH_REAR, 32'sh8000_0000);
    send_item(dequ_pkg::MODE_POP_FRONT, 32'sh1234_5678);
    send_item(dequ_pkg::MODE_PUSH_FRONT, 32'sh7fff_ffff);
    send_item(dequ_pkg::MODE_POP_REAR, -32'sd1);
    send_item(dequ_pkg::MODE_POP_FRONT, -32'sd1);
    send_item(dequ_pkg::MODE_POP_REAR, 32'sh7fff_ffff);
    // fill from both ends, then push into a full queue
    for (int i = 0; i < DEPTH; i++) begin
      send_item(i[0] ? dequ_pkg::MODE_PUSH_FRONT : dequ_pkg::MODE_PUSH_REAR,
                (i == 0) ? '0 : (i == 1) ? -32'sd1 :
                (i[1] ? 32'sh5555_5555 : 32'shaaaa_aaaa) ^ i);
    end
    send_item(dequ_pkg::MODE_PUSH_FRONT, 32'sh0000_0001);
    send_item(dequ_pkg::MODE_PUSH_REAR, 32'sh0000_0002);

    sent      = 2 * DEPTH - 8;
    push_bias = 50;
    while (sent < ITEMS) begin
      if (sent % 32 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_bias = 10;
          1:       push_bias = 50;
          default: push_bias = 90;
        endcase
        sender_eager = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 99) < push_bias) begin
        mode = $urandom_range(0, 1) ? dequ_pkg::MODE_PUSH_FRONT : dequ_pkg::MODE_PUSH_REAR;
      end else begin
        mode = $urandom_range(0, 1) ? dequ_pkg::MODE_POP_FRONT : dequ_pkg::MODE_POP_REAR;
      end
      send_item(mode, pick_value());
      sent++;
    end
    in_valid_i <= 1'b0;

    while (mirror.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.pending.size() == 0) begin
      $display("double_ended_queue_unit test passed");
    end else begin
      $display("double_ended_queue_unit test failed");
    end
    $finish;
  end

endmodule
